/* hdl/point_charge_field_probe_macros.svh */
// Assertion macros used by pcfp_datapath.
`ifndef POINT_CHARGE_FIELD_PROBE_MACROS_SVH
`define POINT_CHARGE_FIELD_PROBE_MACROS_SVH
`ifndef SYNTHESIS
`define PCFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCFP_ASSERT_IMP(lbl, ante, cons, msg)
`define PCFP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/pcfp_pkg.sv */
package pcfp_pkg;

    localparam int FRAC_BITS = 24;
    localparam int XW        = 10;
    localparam int K_W       = 16;
    localparam int D2_W      = 21;
    localparam int SUM_W     = 48;
    localparam int TERM_W    = 41;
    localparam int NUM_W     = 56;
    localparam int DIV_W     = 27;
    localparam int SQV_W     = 54;
    localparam int SQR_W     = 29;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int ENTRY_W   = 2 * XW + 1;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_COLOR = 2'd2;
    localparam logic [1:0] OP_FIELD = 2'd3;

    localparam logic [1:0] SEL_SCALAR = 2'd0;
    localparam logic [1:0] SEL_VX     = 2'd1;
    localparam logic [1:0] SEL_VY     = 2'd2;
    localparam logic [1:0] SEL_POT    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd4;

    typedef struct packed {
        logic       latch_in;
        logic       write_charge;
        logic       clr_count;
        logic       set_full;
        logic       clr_idx;
        logic       read_charge;
        logic       load_probe;
        logic       load_charge;
        logic       calc_delta;
        logic       calc_d2;
        logic       set_sing;
        logic       start_div;
        logic [1:0] div_sel;
        logic       start_sqrt;
        logic       accumulate;
        logic       color_mul;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_full;
        logic       idx_done;
        logic       track_en;
        logic       d2_zero;
        logic       div_busy;
        logic       sqrt_busy;
        logic [1:0] sel;
        logic       out_busy;
    } status_t;

    // floor(c * 255 / 2^24), c in [0, 2^24]
    function automatic logic [7:0] chan8(input logic [24:0] c);
        logic [32:0] p;
        p = {c, 8'b0} - {8'b0, c};
        return p[31:24];
    endfunction

endpackage

/* hdl/pcfp_ram.sv */
module pcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/pcfp_datapath.sv */
`include "point_charge_field_probe_macros.svh"
module pcfp_datapath #(
    parameter int MAX_CHARGES = 256
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [23:0]                               in_data,
    input  logic [1:0]                                in_user,
    input  logic                                      cfg_valid,
    input  logic [pcfp_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [pcfp_pkg::CFG_DAT_W-1:0]            cfg_data,
    input  pcfp_pkg::cmd_t                            cmd,
    output pcfp_pkg::status_t                         status,
    input  logic                                      out_ready,
    output logic                                      out_valid,
    output logic [167:0]                              out_data,
    output logic [1:0]                                out_user
);
    import pcfp_pkg::*;

    localparam int CW = $clog2(MAX_CHARGES + 1);
    localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
    localparam int DCW = $clog2(NUM_W + 1);
    localparam int SCW = $clog2(DIV_W + 1);

    // configuration
    logic            track_reg;
    logic [XW-1:0]   probe_x_reg, probe_y_reg;
    logic [K_W-1:0]  k_reg, gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg   <= 1'b0;
            probe_x_reg <= '0;
            probe_y_reg <= '0;
            k_reg       <= 16'd750;
            gain_reg    <= 16'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRACK: track_reg   <= cfg_data[0];
                CFG_PX:    probe_x_reg <= cfg_data[XW-1:0];
                CFG_PY:    probe_y_reg <= cfg_data[XW-1:0];
                CFG_K:     k_reg       <= cfg_data;
                CFG_GAIN:  gain_reg    <= cfg_data;
                default:   ;
            endcase
        end
    end

    // item registers
    logic [1:0]    op_reg;
    logic [XW-1:0] px_reg, py_reg;
    logic          neg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= in_user;
            px_reg  <= in_data[XW-1:0];
            py_reg  <= in_data[2*XW-1:XW];
            neg_reg <= in_data[2*XW];
        end
    end

    // charge count and walk index
    logic [CW-1:0] count_reg, idx_reg;
    logic          count_full;

    assign count_full = (count_reg == CW'(MAX_CHARGES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.write_charge)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.read_charge)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    logic [ENTRY_W-1:0] rdata;

    pcfp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_CHARGES)
    ) u_table (
        .clk  (clk),
        .we   (cmd.write_charge),
        .waddr(count_reg[AW-1:0]),
        .wdata({neg_reg, py_reg, px_reg}),
        .re   (cmd.read_charge),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rdata)
    );

    // current charge and geometry
    logic [XW-1:0]     cx_reg, cy_reg, adx_reg, ady_reg;
    logic              cneg_reg, sx_reg, sy_reg;
    logic [D2_W-1:0]   d2_reg;
    logic [XW+K_W-1:0] akx_reg, aky_reg;
    logic signed [XW:0] dx, dy;

    assign dx = $signed({1'b0, px_reg}) - $signed({1'b0, cx_reg});
    assign dy = $signed({1'b0, py_reg}) - $signed({1'b0, cy_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load_probe)
        begin
            cx_reg   <= probe_x_reg;
            cy_reg   <= probe_y_reg;
            cneg_reg <= 1'b0;
        end
        else if (cmd.load_charge)
        begin
            cx_reg   <= rdata[XW-1:0];
            cy_reg   <= rdata[2*XW-1:XW];
            cneg_reg <= rdata[2*XW];
        end
        if (cmd.calc_delta)
        begin
            sx_reg  <= dx[XW];
            sy_reg  <= dy[XW];
            adx_reg <= dx[XW] ? XW'(-dx) : dx[XW-1:0];
            ady_reg <= dy[XW] ? XW'(-dy) : dy[XW-1:0];
        end
        if (cmd.calc_d2)
        begin
            d2_reg  <= D2_W'(adx_reg * adx_reg) + D2_W'(ady_reg * ady_reg);
            akx_reg <= adx_reg * k_reg;
            aky_reg <= ady_reg * k_reg;
        end
    end

    // square root, two radicand bits per cycle
    logic [SQV_W-1:0] sv_reg;
    logic [SQR_W-1:0] srem_reg;
    logic [DIV_W-1:0] root_reg;
    logic [SCW-1:0]   scnt_reg;
    logic             sqrt_busy_reg;
    logic [SQR_W+1:0] s_t, s_trial, s_diff;

    assign s_t     = {srem_reg, sv_reg[SQV_W-1:SQV_W-2]};
    assign s_trial = {2'b00, root_reg, 2'b01};
    assign s_diff  = s_t - s_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqrt_busy_reg <= 1'b0;
            scnt_reg      <= '0;
        end
        else if (cmd.start_sqrt)
        begin
            sqrt_busy_reg <= 1'b1;
            scnt_reg      <= SCW'(DIV_W);
        end
        else if (sqrt_busy_reg)
        begin
            scnt_reg <= scnt_reg - 1'b1;
            if (scnt_reg == SCW'(1))
            begin
                sqrt_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_sqrt)
        begin
            sv_reg   <= SQV_W'(d2_reg) << 32;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (sqrt_busy_reg)
        begin
            sv_reg <= {sv_reg[SQV_W-3:0], 2'b00};
            if (s_t >= s_trial)
            begin
                srem_reg <= s_diff[SQR_W-1:0];
                root_reg <= {root_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= s_t[SQR_W-1:0];
                root_reg <= {root_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [1:0]       sel_reg;
    logic [NUM_W-1:0] nq_reg, num;
    logic [DIV_W-1:0] rem_reg, den;
    logic [DCW-1:0]   dcnt_reg;
    logic             div_busy_reg;
    logic [DIV_W:0]   d_t, d_diff;

    always_comb
    begin
        case (cmd.div_sel)
            SEL_SCALAR: num = NUM_W'(k_reg) << FRAC_BITS;
            SEL_VX:     num = NUM_W'(akx_reg) << FRAC_BITS;
            SEL_VY:     num = NUM_W'(aky_reg) << FRAC_BITS;
            default:    num = NUM_W'(k_reg) << (FRAC_BITS + 16);
        endcase
    end

    assign den    = (sel_reg == SEL_POT) ? root_reg : DIV_W'(d2_reg);
    assign d_t    = {rem_reg, nq_reg[NUM_W-1]};
    assign d_diff = d_t - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else if (cmd.start_div)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg     <= DCW'(NUM_W);
        end
        else if (div_busy_reg)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (dcnt_reg == DCW'(1))
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            sel_reg <= cmd.div_sel;
            nq_reg  <= num;
            rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            if (d_t >= {1'b0, den})
            begin
                rem_reg <= d_diff[DIV_W-1:0];
                nq_reg  <= {nq_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= d_t[DIV_W-1:0];
                nq_reg  <= {nq_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // saturating accumulation
    logic signed [SUM_W-1:0] scalar_reg, vx_reg, vy_reg, pot_reg, cur;
    logic signed [SUM_W+1:0] acc_sum, term_ext;
    logic                    tneg;
    logic [SUM_W-1:0]        acc_sat;
    logic                    sing_reg, full_reg;

    always_comb
    begin
        case (sel_reg)
            SEL_SCALAR:
            begin
                cur  = scalar_reg;
                tneg = cneg_reg;
            end
            SEL_VX:
            begin
                cur  = vx_reg;
                tneg = sx_reg ^ cneg_reg;
            end
            SEL_VY:
            begin
                cur  = vy_reg;
                tneg = sy_reg ^ cneg_reg;
            end
            default:
            begin
                cur  = pot_reg;
                tneg = cneg_reg;
            end
        endcase
        term_ext = $signed({9'b0, nq_reg[TERM_W-1:0]});
        acc_sum  = tneg ? ({{2{cur[SUM_W-1]}}, cur} - term_ext)
                        : ({{2{cur[SUM_W-1]}}, cur} + term_ext);
        if (acc_sum[SUM_W+1:SUM_W-1] == 3'b000 || acc_sum[SUM_W+1:SUM_W-1] == 3'b111)
        begin
            acc_sat = acc_sum[SUM_W-1:0];
        end
        else
        begin
            acc_sat = {acc_sum[SUM_W+1], {(SUM_W-1){~acc_sum[SUM_W+1]}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            scalar_reg <= '0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            pot_reg    <= '0;
            sing_reg   <= 1'b0;
            full_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.set_sing)
            begin
                sing_reg <= 1'b1;
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
            if (cmd.accumulate)
            begin
                case (sel_reg)
                    SEL_SCALAR: scalar_reg <= acc_sat;
                    SEL_VX:     vx_reg     <= acc_sat;
                    SEL_VY:     vy_reg     <= acc_sat;
                    default:    pot_reg    <= acc_sat;
                endcase
            end
        end
    end

    // color ramp
    localparam logic signed [SUM_W-1:0] FLIM = 48'sd33554432;
    localparam logic signed [43:0]      NLIM = 44'sd16777216;
    localparam logic signed [26:0]      ONE  = 27'sd16777216;
    localparam logic signed [26:0]      HALF = 27'sd8388608;

    logic signed [26:0] fc, n27, r, g, b;
    logic signed [43:0] prod_reg;
    logic [23:0]        color;

    always_comb
    begin
        if (scalar_reg > FLIM)
        begin
            fc = 27'sd33554432;
        end
        else if (scalar_reg < -FLIM)
        begin
            fc = -27'sd33554432;
        end
        else
        begin
            fc = scalar_reg[26:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.color_mul)
        begin
            prod_reg <= fc * $signed({1'b0, gain_reg});
        end
    end

    always_comb
    begin
        if (prod_reg > NLIM)
        begin
            n27 = ONE;
        end
        else if (prod_reg < -NLIM)
        begin
            n27 = -ONE;
        end
        else
        begin
            n27 = prod_reg[26:0];
        end
        if (n27 <= -HALF)
        begin
            r = -n27;
            g = ONE + n27;
            b = ONE;
        end
        else if (n27 <= 27'sd0)
        begin
            r = -n27;
            g = ONE + n27;
            b = -(n27 <<< 1);
        end
        else if (n27 <= HALF)
        begin
            r = n27 <<< 1;
            g = ONE;
            b = 27'sd0;
        end
        else
        begin
            r = ONE;
            g = (ONE <<< 1) - (n27 <<< 1);
            b = 27'sd0;
        end
        color = {chan8(r[24:0]), chan8(g[24:0]), chan8(b[24:0])};
    end

    // output register
    logic [23:0]      color_reg;
    logic [SUM_W-1:0] ofx_reg, ofy_reg, opot_reg;
    logic             ofull_reg, osing_reg, out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            color_reg <= (op_reg == OP_COLOR) ? color : '0;
            ofx_reg   <= (op_reg == OP_FIELD) ? vx_reg : '0;
            ofy_reg   <= (op_reg == OP_FIELD) ? vy_reg : '0;
            opot_reg  <= (op_reg == OP_FIELD) ? pot_reg : '0;
            ofull_reg <= full_reg;
            osing_reg <= sing_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {opot_reg, ofy_reg, ofx_reg, color_reg};
    assign out_user  = {osing_reg, ofull_reg};

    always_comb
    begin
        status.op         = op_reg;
        status.count_full = count_full;
        status.idx_done   = (idx_reg == count_reg);
        status.track_en   = track_reg;
        status.d2_zero    = (d2_reg == '0);
        status.div_busy   = div_busy_reg;
        status.sqrt_busy  = sqrt_busy_reg;
        status.sel        = sel_reg;
        status.out_busy   = out_valid_reg && !out_ready;
    end

    `PCFP_ASSERT_IMP(a_div_idle, cmd.start_div, !div_busy_reg && !sqrt_busy_reg,
        "divider restarted while busy")
    `PCFP_ASSERT_IMP(a_out_free, cmd.out_load, !out_valid_reg, "result overwritten")
    `PCFP_ASSERT_NXT(a_add_count, cmd.write_charge,
        count_reg == $past(count_reg) + 1'b1 && count_reg <= CW'(MAX_CHARGES),
        "charge count out of step")
endmodule

/* hdl/pcfp_ctrl.sv */
module pcfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcfp_pkg::status_t status,
    output pcfp_pkg::cmd_t    cmd
);
    import pcfp_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_NEXT     = 4'd2;
    localparam logic [3:0] S_RDWAIT   = 4'd3;
    localparam logic [3:0] S_DELTA    = 4'd4;
    localparam logic [3:0] S_D2       = 4'd5;
    localparam logic [3:0] S_CHECK    = 4'd6;
    localparam logic [3:0] S_WDIV     = 4'd7;
    localparam logic [3:0] S_WSQRT    = 4'd8;
    localparam logic [3:0] S_MUL      = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE) && !status.out_busy;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.op)
                    OP_ADD:
                    begin
                        if (status.count_full)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else
                        begin
                            cmd.write_charge = 1'b1;
                        end
                        state_next = S_OUT;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clr_count = 1'b1;
                        state_next    = S_OUT;
                    end
                    default:
                    begin
                        cmd.clr_idx = 1'b1;
                        if (status.track_en)
                        begin
                            cmd.load_probe = 1'b1;
                            state_next     = S_DELTA;
                        end
                        else
                        begin
                            state_next = S_NEXT;
                        end
                    end
                endcase
            end
            S_NEXT:
            begin
                if (status.idx_done)
                begin
                    state_next = (status.op == OP_COLOR) ? S_MUL : S_OUT;
                end
                else
                begin
                    cmd.read_charge = 1'b1;
                    state_next      = S_RDWAIT;
                end
            end
            S_RDWAIT:
            begin
                cmd.load_charge = 1'b1;
                state_next      = S_DELTA;
            end
            S_DELTA:
            begin
                cmd.calc_delta = 1'b1;
                state_next     = S_D2;
            end
            S_D2:
            begin
                cmd.calc_d2 = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.d2_zero)
                begin
                    cmd.set_sing = 1'b1;
                    state_next   = S_NEXT;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = (status.op == OP_COLOR) ? SEL_SCALAR : SEL_VX;
                    state_next    = S_WDIV;
                end
            end
            S_WDIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.accumulate = 1'b1;
                    case (status.sel)
                        SEL_VX:
                        begin
                            cmd.start_div = 1'b1;
                            cmd.div_sel   = SEL_VY;
                        end
                        SEL_VY:
                        begin
                            cmd.start_sqrt = 1'b1;
                            state_next     = S_WSQRT;
                        end
                        default: state_next = S_NEXT;
                    endcase
                end
            end
            S_WSQRT:
            begin
                if (!status.sqrt_busy)
                begin
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = SEL_POT;
                    state_next    = S_WDIV;
                end
            end
            S_MUL:
            begin
                cmd.color_mul = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* hdl/point_charge_field_probe.sv */
// Point charge field probe.
// s_axis: one item per transfer. tuser = operation (add, clear, color probe,
// field probe); tdata = pos_x, pos_y, negative. m_axis: one result per item,
// tdata = color, field_x, field_y, potential; tuser = table_full, singular.
// cfg: register index and data, always ready; write it only while the block
// is idle, which the block does not enforce. Add and clear go from dispatch
// to the output register. A probe walks the tracked probe charge (if enabled)
// and every stored charge; per charge a color probe runs one division and a
// field probe divisions for field_x and field_y, the 27-step square root and
// a potential division. The shared divider (56 steps, one quotient bit a
// cycle) and the root set the per-charge time. Color probes end in a multiply.
// Items are taken one at a time; s_axis_tready is high only while the block
// is idle and the output register is free or being emptied in that cycle.
// Reset empties the charge table, loads the register defaults and drops any
// pending result. A stalled receiver holds the result in the output register
// and the block takes no new item until that result has been transferred.
module point_charge_field_probe #(
    parameter int MAX_CHARGES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,  // pos_x, pos_y, negative
    input  logic [1:0]                          s_axis_tuser,  // operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [167:0]                        m_axis_tdata,  // color, field_x, field_y, potential
    output logic [1:0]                          m_axis_tuser,  // table_full, singular
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcfp_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import pcfp_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    pcfp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    pcfp_datapath #(
        .MAX_CHARGES(MAX_CHARGES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .out_ready(m_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_data (m_axis_tdata),
        .out_user (m_axis_tuser)
    );
endmodule
